/* rtl/sprp_pkg.sv */
package sprp_pkg;

   localparam int IMAGE_SIZE_DEFAULT = 512;
   localparam int SUBSAMPLES_DEFAULT = 10;

   localparam logic [8:0] MOUNT_RESET = 9'd200;

   localparam int unsigned GRAD_TURN  = 400;
   localparam int unsigned TURN_Q8    = 102400;
   localparam int unsigned QUARTER_Q8 = 25600;
   localparam int unsigned ONE_Q15    = 32768;

   localparam int SINE_STAGES = 8;

   localparam int unsigned X_ROUND = 50;
   localparam logic [23:0] X_RECIP = 24'd10737419;

   localparam int unsigned SINE_A1 = 102944;
   localparam int unsigned SINE_A3 = 42334;
   localparam int unsigned SINE_A5 = 5223;
   localparam int unsigned SINE_A7 = 307;
   localparam int unsigned SINE_A9 = 11;

   localparam int unsigned VALUE_RECIP = 6554;

   typedef struct packed {
      logic       sin_neg;
      logic       cos_neg;
      logic [7:0] radius;
      logic [7:0] value;
      logic       last;
   } sprp_side_type;

   typedef struct packed {
      logic          valid;
      logic [14:0]   sin_arg;
      logic [14:0]   cos_arg;
      sprp_side_type side;
   } sprp_issue_type;

   typedef struct packed {
      logic       valid;
      logic [8:0] row;
      logic [8:0] col;
      logic [7:0] value;
      logic       last;
   } sprp_pixel_type;

endpackage

/* rtl/sonar_polar_to_raster_plot_unit.sv */
// Sonar polar-to-raster plotter.
// Each request on the req_ channel is one radial position of a sonar beam.
// For it the block issues SUBSAMPLES pixel writes on the rsp_ channel, with
// angles spread evenly across the beam width, and marks the final write of
// the request with rsp_last_write. The csr_ channel writes the mounting
// rotation, which is always ready and should be written only while idle.
// Each write passes through the input register, the beam generator stages,
// the sine pipelines, the pixel placer and the output register; the single
// result channel carries one write per cycle while rsp_ready does not stall it.
// The next request is accepted in the cycle the beam generator issues its
// predecessor's final write, so that channel sets the request rate.
// Reset empties the pipeline, drops any held request and sets the mounting
// rotation to 200 gradians. While rsp_valid is high and rsp_ready is low,
// the whole pipeline holds its contents; a request can still be taken into
// the input register if no earlier request is waiting there.
module sonar_polar_to_raster_plot_unit #(
   parameter int IMAGE_SIZE = sprp_pkg::IMAGE_SIZE_DEFAULT,
   parameter int SUBSAMPLES = sprp_pkg::SUBSAMPLES_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [8:0] csr_mount_rotation,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [8:0] req_beam_angle,
   input  logic [5:0] req_beam_width,
   input  logic [7:0] req_radius,
   input  logic [7:0] req_intensity,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [8:0] rsp_pixel_row,
   output logic [8:0] rsp_pixel_col,
   output logic [7:0] rsp_pixel_value,
   output logic       rsp_last_write
);

   logic [8:0]                   mount_ff, mount_in;
   logic                         advance;
   sprp_pkg::sprp_issue_type     issue;
   logic [sprp_pkg::SINE_STAGES-1:0] valid_pipe_ff;
   sprp_pkg::sprp_side_type      side_pipe_ff [sprp_pkg::SINE_STAGES];
   logic [15:0]                  sin_mag, cos_mag;
   sprp_pkg::sprp_pixel_type     pixel;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [8:0]                   row_ff, col_ff;
   logic [7:0]                   value_ff;
   logic                         last_ff;

   assign csr_ready    = 1'b1;
   assign mount_in     = (csr_valid && csr_ready) ? csr_mount_rotation : mount_ff;
   assign advance      = !rsp_valid_ff || rsp_ready;
   assign rsp_valid_in = advance ? pixel.valid : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mount_ff <= sprp_pkg::MOUNT_RESET;
      end else begin
         mount_ff <= mount_in;
      end
   end

   sprp_beam_gen #(
      .SUBSAMPLES (SUBSAMPLES)
   ) u_beam_gen (
      .clock          (clock),
      .reset          (reset),
      .advance        (advance),
      .mount_rotation (mount_ff),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_beam_angle (req_beam_angle),
      .req_beam_width (req_beam_width),
      .req_radius     (req_radius),
      .req_intensity  (req_intensity),
      .issue          (issue)
   );

   sprp_quarter_sine u_sin (
      .clock     (clock),
      .advance   (advance),
      .arg       (issue.sin_arg),
      .magnitude (sin_mag)
   );

   sprp_quarter_sine u_cos (
      .clock     (clock),
      .advance   (advance),
      .arg       (issue.cos_arg),
      .magnitude (cos_mag)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_pipe_ff <= '0;
      end else if (advance) begin
         valid_pipe_ff <= {valid_pipe_ff[sprp_pkg::SINE_STAGES-2:0], issue.valid};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         side_pipe_ff[0] <= issue.side;
         for (int i = 1; i < sprp_pkg::SINE_STAGES; i++) begin
            side_pipe_ff[i] <= side_pipe_ff[i-1];
         end
      end
   end

   sprp_pixel_place #(
      .IMAGE_SIZE (IMAGE_SIZE)
   ) u_pixel_place (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .side_valid (valid_pipe_ff[sprp_pkg::SINE_STAGES-1]),
      .side       (side_pipe_ff[sprp_pkg::SINE_STAGES-1]),
      .sin_mag    (sin_mag),
      .cos_mag    (cos_mag),
      .pixel      (pixel)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         row_ff   <= pixel.row;
         col_ff   <= pixel.col;
         value_ff <= pixel.value;
         last_ff  <= pixel.last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel_row   = row_ff;
   assign rsp_pixel_col   = col_ff;
   assign rsp_pixel_value = value_ff;
   assign rsp_last_write  = last_ff;

   a_reset_clears : assert property (@(posedge clock)
      reset |=> (!rsp_valid && req_ready))
      else $error("Block not empty after reset.");

   a_request_holds_slot : assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("A new request was offered a slot before its predecessor issued.");

   a_value_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_pixel_value <= 8'd229))
      else $error("Pixel value exceeds the scaled intensity range.");

endmodule

/* rtl/sprp_quarter_sine.sv */
module sprp_quarter_sine (
   input  logic        clock,
   input  logic        advance,
   input  logic [14:0] arg,
   output logic [15:0] magnitude
);

   logic [22:0] s1_num;
   logic [46:0] s1_prod_in, s1_prod_ff;
   logic [16:0] s2_x;
   logic [33:0] s2_xx_in, s2_xx_ff;
   logic [16:0] s2_x_ff;
   logic [16:0] s3_x2;
   logic [20:0] s3_x2_a9;
   logic [8:0]  s3_t1_in, s3_t1_ff;
   logic [16:0] s3_x_ff, s3_x2_ff;
   logic [25:0] s4_prod_in, s4_prod_ff;
   logic [16:0] s4_x_ff, s4_x2_ff;
   logic [12:0] s5_t2;
   logic [29:0] s5_prod_in, s5_prod_ff;
   logic [16:0] s5_x_ff, s5_x2_ff;
   logic [15:0] s6_t3;
   logic [32:0] s6_prod_in, s6_prod_ff;
   logic [16:0] s6_x_ff;
   logic [16:0] s7_t4;
   logic [33:0] s7_prod_in, s7_prod_ff;
   logic [17:0] s8_round;
   logic [16:0] s8_half;
   logic [15:0] s8_mag_in, s8_mag_ff;

   always_comb begin
      s1_num     = {arg, 8'b0} + 23'(sprp_pkg::X_ROUND);
      s1_prod_in = 47'(s1_num) * 47'(sprp_pkg::X_RECIP);

      s2_x     = s1_prod_ff[46:30];
      s2_xx_in = 34'(s2_x) * 34'(s2_x);

      s3_x2    = s2_xx_ff[32:16];
      s3_x2_a9 = 21'(s3_x2) * 21'(sprp_pkg::SINE_A9);
      s3_t1_in = 9'(sprp_pkg::SINE_A7) - 9'(s3_x2_a9[20:16]);

      s4_prod_in = 26'(s3_x2_ff) * 26'(s3_t1_ff);

      s5_t2      = 13'(sprp_pkg::SINE_A5) - 13'(s4_prod_ff[25:16]);
      s5_prod_in = 30'(s4_x2_ff) * 30'(s5_t2);

      s6_t3      = 16'(sprp_pkg::SINE_A3) - 16'(s5_prod_ff[29:16]);
      s6_prod_in = 33'(s5_x2_ff) * 33'(s6_t3);

      s7_t4      = 17'(sprp_pkg::SINE_A1) - s6_prod_ff[32:16];
      s7_prod_in = 34'(s6_x_ff) * 34'(s7_t4);

      s8_round = s7_prod_ff[33:16] + 18'd1;
      s8_half  = s8_round[17:1];
      if (s8_half > 17'(sprp_pkg::ONE_Q15)) begin
         s8_mag_in = 16'(sprp_pkg::ONE_Q15);
      end else begin
         s8_mag_in = s8_half[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_prod_ff <= s1_prod_in;
         s2_x_ff    <= s2_x;
         s2_xx_ff   <= s2_xx_in;
         s3_x_ff    <= s2_x_ff;
         s3_x2_ff   <= s3_x2;
         s3_t1_ff   <= s3_t1_in;
         s4_x_ff    <= s3_x_ff;
         s4_x2_ff   <= s3_x2_ff;
         s4_prod_ff <= s4_prod_in;
         s5_x_ff    <= s4_x_ff;
         s5_x2_ff   <= s4_x2_ff;
         s5_prod_ff <= s5_prod_in;
         s6_x_ff    <= s5_x_ff;
         s6_prod_ff <= s6_prod_in;
         s7_prod_ff <= s7_prod_in;
         s8_mag_ff  <= s8_mag_in;
      end
   end

   assign magnitude = s8_mag_ff;

endmodule

/* rtl/sprp_beam_gen.sv */
module sprp_beam_gen #(
   parameter int SUBSAMPLES = sprp_pkg::SUBSAMPLES_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     advance,
   input  logic [8:0]               mount_rotation,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [8:0]               req_beam_angle,
   input  logic [5:0]               req_beam_width,
   input  logic [7:0]               req_radius,
   input  logic [7:0]               req_intensity,
   output sprp_pkg::sprp_issue_type issue
);

   localparam int DIV   = SUBSAMPLES - 1;
   localparam int KW    = $clog2(SUBSAMPLES);
   localparam int WKW   = 6 + KW;
   localparam int BW    = WKW + 8;
   localparam int SHIFT = BW + $clog2(DIV);
   localparam int RW    = SHIFT + 1;
   localparam int PW    = BW + RW;
   localparam longint unsigned RECIP = ((longint'(1) << SHIFT) + DIV - 1) / DIV;

   function automatic logic [7:0] scale_value(input logic [7:0] intensity);
      logic [11:0] nine;
      logic [24:0] prod;
      nine = 12'(intensity) * 12'd9;
      prod = 25'(nine) * 25'(sprp_pkg::VALUE_RECIP);
      return prod[23:16];
   endfunction

   logic          busy_ff, busy_in;
   logic [KW-1:0] k_ff, k_in;
   logic [8:0]    angle_ff;
   logic [5:0]    width_ff;
   logic [7:0]    radius_ff;
   logic [7:0]    value_ff;
   logic          accept;
   logic          last_k;
   logic          issue_now;

   logic           a_valid_ff;
   logic [WKW-1:0] a_wk_in, a_wk_ff;
   logic [9:0]     a_sum;
   logic [8:0]     a_base_in, a_base_ff;
   logic [5:0]     a_width_ff;
   sprp_pkg::sprp_side_type a_side_in, a_side_ff;

   logic                    b_valid_ff;
   logic [PW-1:0]           b_prod_in, b_prod_ff;
   logic [8:0]              b_base_ff;
   logic [5:0]              b_width_ff;
   sprp_pkg::sprp_side_type b_side_ff;

   logic [13:0]             c_spread;
   logic [18:0]             c_num;
   logic [16:0]             c_phase_in, c_phase_ff;
   logic                    c_valid_ff;
   sprp_pkg::sprp_side_type c_side_ff;

   logic [1:0]               d_quadrant;
   logic [14:0]              d_p, d_p_rev;
   sprp_pkg::sprp_issue_type d_issue_in, d_issue_ff;
   logic                     d_valid_ff;

   assign last_k    = (k_ff == KW'(DIV));
   assign req_ready = !busy_ff || (advance && last_k);
   assign accept    = req_valid && req_ready;
   assign issue_now = busy_ff && advance;

   always_comb begin
      busy_in = busy_ff;
      k_in    = k_ff;
      priority if (accept) begin
         busy_in = 1'b1;
         k_in    = '0;
      end else if (issue_now && last_k) begin
         busy_in = 1'b0;
         k_in    = '0;
      end else if (issue_now) begin
         k_in = k_ff + KW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         k_ff    <= '0;
      end else begin
         busy_ff <= busy_in;
         k_ff    <= k_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         angle_ff  <= req_beam_angle;
         width_ff  <= req_beam_width;
         radius_ff <= req_radius;
         value_ff  <= scale_value(req_intensity);
      end
   end

   always_comb begin
      a_wk_in = WKW'(width_ff) * WKW'(k_ff);
      a_sum   = {1'b0, angle_ff} + {1'b0, mount_rotation};
      priority if (a_sum >= 10'(2 * sprp_pkg::GRAD_TURN)) begin
         a_base_in = 9'(a_sum - 10'(2 * sprp_pkg::GRAD_TURN));
      end else if (a_sum >= 10'(sprp_pkg::GRAD_TURN)) begin
         a_base_in = 9'(a_sum - 10'(sprp_pkg::GRAD_TURN));
      end else begin
         a_base_in = a_sum[8:0];
      end
      a_side_in         = '0;
      a_side_in.radius  = radius_ff;
      a_side_in.value   = value_ff;
      a_side_in.last    = last_k;
   end

   always_comb begin
      b_prod_in = PW'({a_wk_ff, 8'b0}) * PW'(RECIP);
   end

   always_comb begin
      c_spread = b_prod_ff[SHIFT +: 14];
      c_num    = {2'b0, b_base_ff, 8'b0} + 19'(sprp_pkg::TURN_Q8) + 19'(c_spread)
                 - {6'b0, b_width_ff, 7'b0};
      priority if (c_num >= 19'(2 * sprp_pkg::TURN_Q8)) begin
         c_phase_in = 17'(c_num - 19'(2 * sprp_pkg::TURN_Q8));
      end else if (c_num >= 19'(sprp_pkg::TURN_Q8)) begin
         c_phase_in = 17'(c_num - 19'(sprp_pkg::TURN_Q8));
      end else begin
         c_phase_in = c_num[16:0];
      end
   end

   always_comb begin
      priority if (c_phase_ff >= 17'(3 * sprp_pkg::QUARTER_Q8)) begin
         d_quadrant = 2'd3;
         d_p        = 15'(c_phase_ff - 17'(3 * sprp_pkg::QUARTER_Q8));
      end else if (c_phase_ff >= 17'(2 * sprp_pkg::QUARTER_Q8)) begin
         d_quadrant = 2'd2;
         d_p        = 15'(c_phase_ff - 17'(2 * sprp_pkg::QUARTER_Q8));
      end else if (c_phase_ff >= 17'(sprp_pkg::QUARTER_Q8)) begin
         d_quadrant = 2'd1;
         d_p        = 15'(c_phase_ff - 17'(sprp_pkg::QUARTER_Q8));
      end else begin
         d_quadrant = 2'd0;
         d_p        = c_phase_ff[14:0];
      end
      d_p_rev = 15'(sprp_pkg::QUARTER_Q8) - d_p;

      d_issue_in              = '0;
      d_issue_in.valid        = c_valid_ff;
      d_issue_in.sin_arg      = d_quadrant[0] ? d_p_rev : d_p;
      d_issue_in.cos_arg      = d_quadrant[0] ? d_p : d_p_rev;
      d_issue_in.side         = c_side_ff;
      d_issue_in.side.sin_neg = d_quadrant[1];
      d_issue_in.side.cos_neg = d_quadrant[1] ^ d_quadrant[0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
      end else if (advance) begin
         a_valid_ff <= issue_now;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
         d_valid_ff <= d_issue_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a_wk_ff    <= a_wk_in;
         a_base_ff  <= a_base_in;
         a_width_ff <= width_ff;
         a_side_ff  <= a_side_in;
         b_prod_ff  <= b_prod_in;
         b_base_ff  <= a_base_ff;
         b_width_ff <= a_width_ff;
         b_side_ff  <= a_side_ff;
         c_phase_ff <= c_phase_in;
         c_side_ff  <= b_side_ff;
         d_issue_ff <= d_issue_in;
      end
   end

   always_comb begin
      issue       = d_issue_ff;
      issue.valid = d_valid_ff;
   end

endmodule

/* rtl/sprp_pixel_place.sv */
module sprp_pixel_place #(
   parameter int IMAGE_SIZE = sprp_pkg::IMAGE_SIZE_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     advance,
   input  logic                     side_valid,
   input  sprp_pkg::sprp_side_type  side,
   input  logic [15:0]              sin_mag,
   input  logic [15:0]              cos_mag,
   output sprp_pkg::sprp_pixel_type pixel
);

   localparam int IW = $clog2(IMAGE_SIZE);
   localparam int VW = ((IW > 8) ? IW : 8) + 17;
   localparam int FW = VW - 15;
   localparam logic signed [VW-1:0] HALF_Q  = VW'((IMAGE_SIZE / 2) * 32768);
   localparam logic signed [VW-1:0] ONE_V   = VW'(1);
   localparam logic signed [FW-1:0] MAX_POS = FW'(IMAGE_SIZE - 1);

   function automatic logic [8:0] coord(input logic [23:0] prod, input logic sub);
      logic signed [VW-1:0] val;
      logic signed [FW-1:0] fl;
      logic [8:0]           res;
      if (sub) begin
         val = HALF_Q - $signed(VW'(prod));
      end else begin
         val = HALF_Q + $signed(VW'(prod));
      end
      fl = FW'((val >>> 15) - ONE_V);
      priority if (fl[FW-1]) begin
         res = '0;
      end else if (fl > MAX_POS) begin
         res = MAX_POS[8:0];
      end else begin
         res = fl[8:0];
      end
      return res;
   endfunction

   logic        valid_ff;
   logic [23:0] sin_prod_in, sin_prod_ff;
   logic [23:0] cos_prod_in, cos_prod_ff;
   logic        sin_neg_ff, cos_neg_ff;
   logic [7:0]  value_ff;
   logic        last_ff;

   assign sin_prod_in = 24'(side.radius) * 24'(sin_mag);
   assign cos_prod_in = 24'(side.radius) * 24'(cos_mag);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= side_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sin_prod_ff <= sin_prod_in;
         cos_prod_ff <= cos_prod_in;
         sin_neg_ff  <= side.sin_neg;
         cos_neg_ff  <= side.cos_neg;
         value_ff    <= side.value;
         last_ff     <= side.last;
      end
   end

   always_comb begin
      pixel       = '0;
      pixel.valid = valid_ff;
      pixel.row   = coord(cos_prod_ff, !cos_neg_ff);
      pixel.col   = coord(sin_prod_ff, sin_neg_ff);
      pixel.value = value_ff;
      pixel.last  = last_ff;
   end

endmodule

/* tb/sprp_pixel_write_checker.sv */
`timescale 1ns / 1ps

module sprp_pixel_write_checker #(
   parameter int IMAGE_SIZE = sprp_pkg::IMAGE_SIZE_DEFAULT,
   parameter int SUBSAMPLES = sprp_pkg::SUBSAMPLES_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_valid,
   input  logic       csr_ready,
   input  logic [8:0] csr_mount_rotation,
   input  logic       req_valid,
   input  logic       req_ready,
   input  logic [8:0] req_beam_angle,
   input  logic [5:0] req_beam_width,
   input  logic [7:0] req_radius,
   input  logic [7:0] req_intensity,
   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  logic [8:0] rsp_pixel_row,
   input  logic [8:0] rsp_pixel_col,
   input  logic [7:0] rsp_pixel_value,
   input  logic       rsp_last_write,
   output int         mismatches,
   output int         pending,
   output int         writes_checked
);

   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic [8:0] row;
      logic [8:0] col;
      logic [7:0] value;
      logic       last;
   } pixel_write_type;

   pixel_write_type expected_writes[$];
   logic [8:0]      mount_rotation = sprp_pkg::MOUNT_RESET;
   int              mismatch_total = 0;
   int              checked_total = 0;

   function automatic longint quarter_wave(longint unsigned p);
      longint unsigned x, x2, t, s;
      x = (p * 65536 + sprp_pkg::QUARTER_Q8 / 2) / sprp_pkg::QUARTER_Q8;
      x2 = (x * x) >> 16;
      t = sprp_pkg::SINE_A7 - ((x2 * sprp_pkg::SINE_A9) >> 16);
      t = sprp_pkg::SINE_A5 - ((x2 * t) >> 16);
      t = sprp_pkg::SINE_A3 - ((x2 * t) >> 16);
      t = sprp_pkg::SINE_A1 - ((x2 * t) >> 16);
      s = (x * t) >> 16;
      s = (s + 1) >> 1;
      if (s > sprp_pkg::ONE_Q15) s = sprp_pkg::ONE_Q15;
      return longint'(s);
   endfunction

   function automatic longint sine_of_phase(longint unsigned phase);
      longint unsigned quadrant, p;
      quadrant = (phase / sprp_pkg::QUARTER_Q8) % 4;
      p = phase % sprp_pkg::QUARTER_Q8;
      case (quadrant)
         0: return quarter_wave(p);
         1: return quarter_wave(sprp_pkg::QUARTER_Q8 - p);
         2: return -quarter_wave(p);
         default: return -quarter_wave(sprp_pkg::QUARTER_Q8 - p);
      endcase
   endfunction

   function automatic logic [8:0] pixel_coord(logic [7:0] radius, longint trig, bit add);
      longint one, center, prod, val, fl;
      one = sprp_pkg::ONE_Q15;
      center = IMAGE_SIZE / 2;
      prod = longint'(radius) * trig;
      val = center * one + (add ? prod : -prod);
      if (val >= 0) begin
         fl = val / one;
      end else begin
         fl = -((-val + one - 1) / one);
      end
      fl = fl - 1;
      if (fl < 0) fl = 0;
      if (fl > IMAGE_SIZE - 1) fl = IMAGE_SIZE - 1;
      return fl[8:0];
   endfunction

   function automatic void predict_writes(logic [8:0] angle, logic [5:0] width,
                                          logic [7:0] radius, logic [7:0] intensity);
      longint unsigned base, spread, phase;
      longint          sin_q15, cos_q15;
      pixel_write_type w;
      base = (64'(angle) + 64'(mount_rotation)) * 256 + sprp_pkg::TURN_Q8
             - 64'(width) * 128;
      for (int k = 0; k < SUBSAMPLES; k++) begin
         spread = 64'(width) * 256 * k / (SUBSAMPLES - 1);
         phase = (base + spread) % sprp_pkg::TURN_Q8;
         sin_q15 = sine_of_phase(phase);
         cos_q15 = sine_of_phase((phase + sprp_pkg::QUARTER_Q8) % sprp_pkg::TURN_Q8);
         w.row = pixel_coord(radius, cos_q15, 1'b0);
         w.col = pixel_coord(radius, sin_q15, 1'b1);
         w.value = 8'((16'(intensity) * 9) / 10);
         w.last = (k == SUBSAMPLES - 1);
         expected_writes.insert(expected_writes.size(), w);
      end
   endfunction

   function automatic void note_mismatch(string what, pixel_write_type want,
                                         pixel_write_type seen);
      mismatch_total++;
      if (mismatch_total <= REPORT_LIMIT) begin
         $display("[%0t] %s: expected row %0d col %0d value %0d last %0b,",
                  $realtime, what, want.row, want.col, want.value, want.last);
         $display("      got row %0d col %0d value %0d last %0b",
                  seen.row, seen.col, seen.value, seen.last);
      end
   endfunction

   always @(posedge clock) begin
      pixel_write_type seen;
      pixel_write_type want;
      if (reset) begin
         mount_rotation = sprp_pkg::MOUNT_RESET;
         expected_writes.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            seen = '{rsp_pixel_row, rsp_pixel_col, rsp_pixel_value, rsp_last_write};
            if (expected_writes.size() == 0) begin
               note_mismatch("pixel write with no request pending", '0, seen);
            end else begin
               want = expected_writes.pop_front();
               checked_total++;
               if (seen !== want) note_mismatch("pixel write mismatch", want, seen);
            end
         end
         if (csr_valid && csr_ready) mount_rotation = csr_mount_rotation;
         if (req_valid && req_ready) begin
            predict_writes(req_beam_angle, req_beam_width, req_radius, req_intensity);
         end
      end
      mismatches <= mismatch_total;
      pending <= expected_writes.size();
      writes_checked <= checked_total;
   end

endmodule

/* tb/sonar_polar_to_raster_plot_unit_test.sv */
`timescale 1ns / 1ps

module sonar_polar_to_raster_plot_unit_test;

   localparam int WATCHDOG_LIMIT = 1000;
   localparam int SETTLE_CYCLES = 30;
   localparam int ITEMS_PER_SETTING = 25;
   localparam int SETTING_COUNT = 6;

   typedef enum logic [1:0] {READY_ALWAYS, READY_RANDOM, READY_PERIODIC} ready_pattern_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       csr_valid = 1'b0;
   logic [8:0] csr_mount_rotation = 9'd0;
   logic       req_valid = 1'b0;
   logic [8:0] req_beam_angle = 9'd0;
   logic [5:0] req_beam_width = 6'd0;
   logic [7:0] req_radius = 8'd0;
   logic [7:0] req_intensity = 8'd0;
   logic       rsp_ready = 1'b0;
   logic       csr_ready;
   logic       req_ready;
   logic       rsp_valid;
   logic [8:0] rsp_pixel_row;
   logic [8:0] rsp_pixel_col;
   logic [7:0] rsp_pixel_value;
   logic       rsp_last_write;

   int mismatches;
   int pending;
   int writes_checked;

   int                burst_left = 0;
   int                requests_sent = 0;
   int                directed_sent = 0;
   int                settings_used = 1;
   int                idle_cycles = 0;
   int                stall_tick = 0;
   ready_pattern_type stall_mode = READY_ALWAYS;
   logic [8:0]        rotations [0:SETTING_COUNT-1];

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   sonar_polar_to_raster_plot_unit uut (
      .clock              (clock),
      .reset              (reset),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_mount_rotation (csr_mount_rotation),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_beam_angle     (req_beam_angle),
      .req_beam_width     (req_beam_width),
      .req_radius         (req_radius),
      .req_intensity      (req_intensity),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_pixel_row      (rsp_pixel_row),
      .rsp_pixel_col      (rsp_pixel_col),
      .rsp_pixel_value    (rsp_pixel_value),
      .rsp_last_write     (rsp_last_write)
   );

   sprp_pixel_write_checker pixel_check (
      .clock              (clock),
      .reset              (reset),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_mount_rotation (csr_mount_rotation),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_beam_angle     (req_beam_angle),
      .req_beam_width     (req_beam_width),
      .req_radius         (req_radius),
      .req_intensity      (req_intensity),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_pixel_row      (rsp_pixel_row),
      .rsp_pixel_col      (rsp_pixel_col),
      .rsp_pixel_value    (rsp_pixel_value),
      .rsp_last_write     (rsp_last_write),
      .mismatches         (mismatches),
      .pending            (pending),
      .writes_checked     (writes_checked)
   );

   always @(posedge clock) begin
      stall_tick <= stall_tick + 1;
      if (stall_tick % 64 == 0) stall_mode <= ready_pattern_type'($urandom_range(0, 2));
      case (stall_mode)
         READY_ALWAYS: rsp_ready <= 1'b1;
         READY_RANDOM: rsp_ready <= ($urandom_range(0, 2) != 0);
         default: rsp_ready <= (stall_tick % 7) > 2;
      endcase
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog expired with %0d pixel writes outstanding.", pending);
         $display("TB_ERROR");
         $finish;
      end
   end

   task automatic send_beam(input logic [8:0] angle, input logic [5:0] width,
                            input logic [7:0] radius, input logic [7:0] intensity);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = $urandom_range(1, 16);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_beam_angle <= angle;
      req_beam_width <= width;
      req_radius <= radius;
      req_intensity <= intensity;
      do @(posedge clock); while (!req_ready);
      requests_sent++;
   endtask

   task automatic send_random_beam();
      logic [8:0] angle;
      if ($urandom_range(0, 7) == 0) begin
         angle = 9'($urandom_range(400, 511));
      end else begin
         angle = 9'($urandom_range(0, 399));
      end
      send_beam(angle, 6'($urandom_range(0, 63)), 8'($urandom_range(0, 255)),
                8'($urandom_range(0, 255)));
   endtask

   task automatic drain_pipeline();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_mount(input logic [8:0] rotation);
      drain_pipeline();
      csr_valid <= 1'b1;
      csr_mount_rotation <= rotation;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   initial begin
      rotations[0] = 9'd0;
      rotations[1] = 9'd399;
      rotations[2] = 9'd511;
      rotations[3] = 9'd1;
      rotations[4] = 9'($urandom_range(0, 511));
      rotations[5] = sprp_pkg::MOUNT_RESET;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Edge cases run under the reset mounting rotation.
      send_beam(9'd0, 6'd0, 8'd0, 8'd0);
      send_beam(9'd0, 6'd0, 8'd255, 8'd255);
      send_beam(9'd100, 6'd0, 8'd255, 8'd128);
      send_beam(9'd200, 6'd0, 8'd255, 8'd200);
      send_beam(9'd300, 6'd0, 8'd255, 8'd17);
      send_beam(9'd399, 6'd63, 8'd255, 8'd255);
      send_beam(9'd511, 6'd63, 8'd255, 8'd1);
      send_beam(9'd0, 6'd63, 8'd128, 8'd100);
      send_beam(9'd50, 6'd1, 8'd200, 8'd9);
      send_beam(9'd250, 6'd32, 8'd255, 8'd10);
      send_beam(9'd400, 6'd20, 8'd64, 8'd11);
      send_beam(9'd256, 6'd42, 8'd1, 8'd254);
      send_beam(9'd150, 6'd21, 8'd127, 8'd85);
      send_beam(9'd350, 6'd63, 8'd0, 8'd170);
      send_beam(9'd199, 6'd2, 8'd255, 8'd0);
      send_beam(9'd455, 6'd62, 8'd170, 8'd229);
      directed_sent = requests_sent;

      for (int s = 0; s < SETTING_COUNT; s++) begin
         write_mount(rotations[s]);
         for (int i = 0; i < ITEMS_PER_SETTING; i++) begin
            if ($urandom_range(0, 39) == 0) drain_pipeline();
            send_random_beam();
         end
      end
      drain_pipeline();

      $display("Checked %0d pixel writes from %0d beam requests (%0d directed).",
               writes_checked, requests_sent, directed_sent);
      $display("Mounting rotation was set %0d times, including 0, 399 and 511.",
               settings_used);
      if (mismatches == 0 && pending == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

/* files.f */
rtl/sprp_pkg.sv
rtl/sprp_quarter_sine.sv
rtl/sprp_beam_gen.sv
rtl/sprp_pixel_place.sv
rtl/sonar_polar_to_raster_plot_unit.sv
tb/sprp_pixel_write_checker.sv
tb/sonar_polar_to_raster_plot_unit_test.sv
